### rtl/rail_car_reorder_tracks_macros.svh
// Assertion macros shared by the rail car reorder RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef RAIL_CAR_REORDER_TRACKS_MACROS_SVH
`define RAIL_CAR_REORDER_TRACKS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rcrt_pkg.sv
// Shared types and constants for the rail car reorder block.
// Used by rcrt_track_sel and rail_car_reorder_tracks; no dependencies.
`default_nettype none

package rcrt_pkg;

  // Default sizes of the block.
  localparam int TRACKS_DEF      = 4;
  localparam int TRACK_DEPTH_DEF = 15;
  localparam int CAR_BITS_DEF    = 8;

  // Fixed port widths.
  localparam int CAR_IN_W  = 8;
  localparam int SRC_W     = 3;
  localparam int CNT_REG_W = 3;
  localparam int IDX_W     = 3;

  localparam logic [CNT_REG_W-1:0] TRACK_COUNT_RESET = 3'd4;
  localparam int                   FIRST_CAR         = 1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CAR_OUT    = 2'd0,
    ST_UNSOLVABLE = 2'd1,
    ST_TRACK_FULL = 2'd2,
    ST_HALTED     = 2'd3
  } status_t;

  // Outcome of the parallel search over the holding tracks.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             best_ok;
    logic [IDX_W-1:0] best_idx;
    logic             empty_ok;
    logic [IDX_W-1:0] empty_idx;
  } sel_t;

endpackage

`default_nettype wire

### rtl/rcrt_track_mem.sv
// Car storage for all holding tracks: one write port, one read port.
// Read data is registered; no package dependency.
`default_nettype none

module rcrt_track_mem #(
  parameter int DEPTH = 60,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/rcrt_track_sel.sv
// Parallel search over track fronts and backs for the reorder controller.
// Depends on rcrt_pkg for the sel_t result struct.
`default_nettype none

module rcrt_track_sel #(
  parameter int TRACKS   = rcrt_pkg::TRACKS_DEF,
  parameter int CAR_BITS = rcrt_pkg::CAR_BITS_DEF,
  parameter int CNT_W    = $clog2(TRACKS + 1)
) (
  input  wire logic [TRACKS-1:0][CAR_BITS-1:0] front,
  input  wire logic [TRACKS-1:0][CAR_BITS-1:0] back,
  input  wire logic [TRACKS-1:0]               nonempty,
  input  wire logic [CNT_W-1:0]                cnt,
  input  wire logic [CAR_BITS-1:0]             probe,
  input  wire logic [CAR_BITS-1:0]             car,
  output rcrt_pkg::sel_t                       sel
);

  logic [CAR_BITS-1:0] best_val;
  logic                usable;

  always_comb begin
    sel      = '0;
    best_val = '0;
    usable   = 1'b0;
    for (int t = 0; t < TRACKS; t++) begin
      usable = (CNT_W'(t) < cnt);
      // Lowest usable track whose front is the expected car.
      if (usable && nonempty[t] && (front[t] == probe) && !sel.hit) begin
        sel.hit     = 1'b1;
        sel.hit_idx = rcrt_pkg::IDX_W'(t);
      end
      // Largest tail below the car; ties go to the higher index.
      if (usable && nonempty[t] && (back[t] < car) &&
          (!sel.best_ok || (back[t] >= best_val))) begin
        sel.best_ok  = 1'b1;
        sel.best_idx = rcrt_pkg::IDX_W'(t);
        best_val     = back[t];
      end
      // Lowest usable empty track.
      if (usable && !nonempty[t] && !sel.empty_ok) begin
        sel.empty_ok  = 1'b1;
        sel.empty_idx = rcrt_pkg::IDX_W'(t);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rail_car_reorder_tracks.sv
// Rail car reorder block: accepts one car per item, parks it on a holding track or
// sends it out and drains matching track fronts. A parked car gives no result. A car
// sent out is held in S_CHECK until the output register is free; each drained car passes
// S_CHECK again, after S_LOAD when the popped track must refresh its front from storage.
// The next item is taken in idle, once the last result is in a free output register.
// Synchronous reset clears track pointers, fills and halt; sets expected car 1, count 4.
`default_nettype none

module rail_car_reorder_tracks #(
  parameter int TRACKS      = rcrt_pkg::TRACKS_DEF,
  parameter int TRACK_DEPTH = rcrt_pkg::TRACK_DEPTH_DEF,
  parameter int CAR_BITS    = rcrt_pkg::CAR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rcrt_pkg::CAR_IN_W-1:0]  in_car_number,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rcrt_pkg::CAR_IN_W-1:0]  out_car,
  output logic      [rcrt_pkg::SRC_W-1:0]     out_source_track,
  output logic      [1:0]                     out_status,
  output logic                                out_last,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rcrt_pkg::CNT_REG_W-1:0] cfg_track_count
);

  localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PTR_W  = $clog2(TRACK_DEPTH);
  localparam int FILL_W = $clog2(TRACK_DEPTH + 1);
  localparam int MEM_D  = TRACKS * TRACK_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int CNT_W  = $clog2(TRACKS + 1);
  localparam int SRC_W  = rcrt_pkg::SRC_W;
  localparam int CIN_W  = rcrt_pkg::CAR_IN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD
  } state_t;

  // Control state.
  state_t                          state_r, state_nxt;
  logic                            halted_r, halted_nxt;
  logic [CAR_BITS-1:0]             next_exp_r, next_exp_nxt;
  logic [rcrt_pkg::CNT_REG_W-1:0]  track_count_r;
  logic [PTR_W-1:0]                head_r [TRACKS];
  logic [PTR_W-1:0]                head_nxt [TRACKS];
  logic [PTR_W-1:0]                tail_r [TRACKS];
  logic [PTR_W-1:0]                tail_nxt [TRACKS];
  logic [FILL_W-1:0]               fill_r [TRACKS];
  logic [FILL_W-1:0]               fill_nxt [TRACKS];
  logic                            out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [TRACKS-1:0][CAR_BITS-1:0] front_r, front_nxt;
  logic [TRACKS-1:0][CAR_BITS-1:0] back_r, back_nxt;
  logic [CAR_BITS-1:0]             pend_car_r, pend_car_nxt;
  logic [SRC_W-1:0]                pend_src_r, pend_src_nxt;
  logic [TRK_W-1:0]                ld_trk_r, ld_trk_nxt;
  logic [CIN_W-1:0]                out_car_r, out_car_nxt;
  logic [SRC_W-1:0]                out_src_r, out_src_nxt;
  rcrt_pkg::status_t               out_status_r, out_status_nxt;
  logic                            out_last_r, out_last_nxt;

  // Datapath signals.
  logic                            in_acc;
  logic                            out_free;
  logic [CNT_W-1:0]                eff_cnt;
  logic [CAR_BITS+CIN_W-1:0]       car_ext;
  logic [CAR_BITS-1:0]             car_in;
  logic [CAR_BITS+CIN_W-1:0]       pend_ext;
  logic [TRACKS-1:0]               nonempty;
  rcrt_pkg::sel_t                  sel;
  logic [TRK_W-1:0]                hit_t;
  logic [TRK_W-1:0]                best_t;
  logic [TRK_W-1:0]                push_t;
  logic                            push_en;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [ADDR_W-1:0]               mem_raddr;
  logic [CAR_BITS-1:0]             mem_rdata;
  logic                            fill_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(TRACK_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] trk_addr(input logic [TRK_W-1:0] t,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(t) * ADDR_W'(TRACK_DEPTH) + ADDR_W'(p);
  endfunction

  // Width conversion between the port and the internal car number.
  assign car_ext  = {{CAR_BITS{1'b0}}, in_car_number};
  assign car_in   = car_ext[CAR_BITS-1:0];
  assign pend_ext = {{CIN_W{1'b0}}, pend_car_r};

  // Usable track count saturates at the number of tracks built.
  assign eff_cnt = (int'(track_count_r) > TRACKS) ? CNT_W'(TRACKS) : CNT_W'(track_count_r);

  always_comb begin
    for (int t = 0; t < TRACKS; t++) begin
      nonempty[t] = (fill_r[t] != '0);
    end
  end

  // Handshakes: items enter only in idle with room in the output register.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  rcrt_track_sel #(
    .TRACKS   (TRACKS),
    .CAR_BITS (CAR_BITS),
    .CNT_W    (CNT_W)
  ) u_sel (
    .front    (front_r),
    .back     (back_r),
    .nonempty (nonempty),
    .cnt      (eff_cnt),
    .probe    (next_exp_r),
    .car      (car_in),
    .sel      (sel)
  );

  assign hit_t  = sel.hit_idx[TRK_W-1:0];
  assign best_t = sel.best_idx[TRK_W-1:0];

  rcrt_track_mem #(
    .DEPTH (MEM_D),
    .WIDTH (CAR_BITS),
    .AW    (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (car_in),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Next-state logic of the controller.
  always_comb begin
    state_nxt      = state_r;
    halted_nxt     = halted_r;
    next_exp_nxt   = next_exp_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    pend_car_nxt   = pend_car_r;
    pend_src_nxt   = pend_src_r;
    ld_trk_nxt     = ld_trk_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_car_nxt    = out_car_r;
    out_src_nxt    = out_src_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    push_en        = 1'b0;
    push_t         = sel.best_ok ? best_t : sel.empty_idx[TRK_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (halted_r) begin
            out_valid_nxt  = 1'b1;
            out_car_nxt    = '0;
            out_src_nxt    = '0;
            out_status_nxt = rcrt_pkg::ST_HALTED;
            out_last_nxt   = 1'b1;
          end else if (car_in == next_exp_r) begin
            // Hold the car until we know whether a drain follows it.
            pend_car_nxt = car_in;
            pend_src_nxt = '0;
            next_exp_nxt = next_exp_r + CAR_BITS'(1);
            state_nxt    = S_CHECK;
          end else if (!sel.best_ok && !sel.empty_ok) begin
            halted_nxt     = 1'b1;
            out_valid_nxt  = 1'b1;
            out_car_nxt    = '0;
            out_src_nxt    = '0;
            out_status_nxt = rcrt_pkg::ST_UNSOLVABLE;
            out_last_nxt   = 1'b1;
          end else if (sel.best_ok && (fill_r[best_t] == FILL_W'(TRACK_DEPTH))) begin
            out_valid_nxt  = 1'b1;
            out_car_nxt    = '0;
            out_src_nxt    = sel.best_idx + SRC_W'(1);
            out_status_nxt = rcrt_pkg::ST_TRACK_FULL;
            out_last_nxt   = 1'b1;
          end else begin
            push_en = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (out_free) begin
          // Send the held car; it is last unless another front matches.
          out_valid_nxt  = 1'b1;
          out_car_nxt    = pend_ext[CIN_W-1:0];
          out_src_nxt    = pend_src_r;
          out_status_nxt = rcrt_pkg::ST_CAR_OUT;
          out_last_nxt   = !sel.hit;
          if (sel.hit) begin
            pend_car_nxt     = front_r[hit_t];
            pend_src_nxt     = sel.hit_idx + SRC_W'(1);
            next_exp_nxt     = next_exp_r + CAR_BITS'(1);
            head_nxt[hit_t]  = ptr_inc(head_r[hit_t]);
            fill_nxt[hit_t]  = fill_r[hit_t] - FILL_W'(1);
            if (fill_r[hit_t] > FILL_W'(1)) begin
              // Fetch the new front of the popped track.
              mem_raddr  = trk_addr(hit_t, ptr_inc(head_r[hit_t]));
              ld_trk_nxt = hit_t;
              state_nxt  = S_LOAD;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        front_nxt[ld_trk_r] = mem_rdata;
        state_nxt           = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Park the car at the tail of the chosen track.
    if (push_en) begin
      mem_we           = 1'b1;
      mem_waddr        = trk_addr(push_t, tail_r[push_t]);
      tail_nxt[push_t] = ptr_inc(tail_r[push_t]);
      fill_nxt[push_t] = fill_r[push_t] + FILL_W'(1);
      back_nxt[push_t] = car_in;
      if (fill_r[push_t] == '0) begin
        front_nxt[push_t] = car_in;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      halted_r      <= 1'b0;
      next_exp_r    <= CAR_BITS'(rcrt_pkg::FIRST_CAR);
      track_count_r <= rcrt_pkg::TRACK_COUNT_RESET;
      out_valid_r   <= 1'b0;
      for (int t = 0; t < TRACKS; t++) begin
        head_r[t] <= '0;
        tail_r[t] <= '0;
        fill_r[t] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      halted_r     <= halted_nxt;
      next_exp_r   <= next_exp_nxt;
      out_valid_r  <= out_valid_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      if (cfg_wr_en) begin
        track_count_r <= cfg_track_count;
      end
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      pend_car_r   <= pend_car_nxt;
      pend_src_r   <= pend_src_nxt;
      ld_trk_r     <= ld_trk_nxt;
      out_car_r    <= out_car_nxt;
      out_src_r    <= out_src_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_car          = out_car_r;
  assign out_source_track = out_src_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // No track ever holds more cars than its depth.
  always_comb begin
    fill_ok = 1'b1;
    for (int t = 0; t < TRACKS; t++) begin
      if (fill_r[t] > FILL_W'(TRACK_DEPTH)) begin
        fill_ok = 1'b0;
      end
    end
  end

`include "rail_car_reorder_tracks_macros.svh"

  `RCRT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ok, "track fill exceeds depth")
  `RCRT_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt cleared without reset")
  `RCRT_ASSERT_IMPL(a_load_after_check, state_r == S_LOAD, $past(state_r) == S_CHECK,
                    "front load not preceded by a pop")
  `RCRT_ASSERT_IMPL(a_nonlast_in_drain, out_valid_r && !out_last_r,
                    state_r == S_CHECK || state_r == S_LOAD,
                    "non-final result while not draining")

endmodule

`default_nettype wire
